// File: hdl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// No dependencies; the other files that use it refer to this package by scoped names.
package cau_pkg;

    // Number of restoring-division steps; also the number of root steps.
    localparam int DIV_STEPS = 24;

    localparam logic signed [23:0] RES_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] RES_MIN = 24'sh800000;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    // Input payload as seen by the first stage
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] a_real;
        logic signed [15:0] a_imag;
        logic signed [15:0] b_real;
        logic signed [15:0] b_imag;
    } in_item_t;

    // After the multiplier stage
    typedef struct packed {
        op_t                op;
        logic signed [31:0] rr;
        logic signed [31:0] ii;
        logic signed [31:0] ri;
        logic signed [31:0] ir;
        logic [31:0]        aa_r;
        logic [31:0]        aa_i;
        logic [31:0]        bb_r;
        logic [31:0]        bb_i;
        logic signed [16:0] pre_re;
        logic signed [16:0] pre_im;
    } prod_t;

    // After the summing stage
    typedef struct packed {
        op_t         op;
        logic [32:0] mul_re;
        logic [32:0] mul_im;
        logic [32:0] num_re;
        logic [32:0] num_im;
        logic [31:0] den;
        logic [31:0] ss;
        logic [16:0] pre_re;
        logic [16:0] pre_im;
    } sum_t;

    // One divider lane: dividend bits still to shift in, partial remainder, quotient
    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [23:0] m_sh;
        logic [31:0] rem;
        logic [23:0] q;
    } lane_t;

    // Item travelling through the iterative steps
    typedef struct packed {
        op_t                op;
        logic signed [24:0] pass_re;
        logic signed [24:0] pass_im;
        lane_t              lre;
        lane_t              lim;
        logic [31:0]        den;
        logic               dz;
        logic [47:0]        s_sh;
        logic [15:0]        root;
        logic [16:0]        srem;
    } item_t;

endpackage

// File: hdl/cau_if.sv
// Handshake channel interfaces for the complex arithmetic unit.
// Depends on nothing; used by the top level.
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [15:0] a_real;
    logic signed [15:0] a_imag;
    logic signed [15:0] b_real;
    logic signed [15:0] b_imag;

    modport source (output valid, opcode, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, opcode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] res_real;
    logic signed [23:0] res_imag;
    logic [1:0]         status;

    modport source (output valid, res_real, res_imag, status, input ready);
    modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

// File: hdl/cau_front.sv
// Front end: products, sums and per-operation preparation (three register stages).
// Depends on cau_pkg.
module cau_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  cau_pkg::in_item_t in_item,
    output logic              out_valid,
    output cau_pkg::item_t    out_item
);

    logic           p_valid_reg, s_valid_reg, i_valid_reg;
    cau_pkg::prod_t p_reg, p_next;
    cau_pkg::sum_t  s_reg, s_next;
    cau_pkg::item_t i_reg, i_next;

    // Stage 1: all products and the add/subtract result
    always_comb
    begin
        p_next.op   = cau_pkg::op_t'(in_item.opcode);
        p_next.rr   = in_item.a_real * in_item.b_real;
        p_next.ii   = in_item.a_imag * in_item.b_imag;
        p_next.ri   = in_item.a_real * in_item.b_imag;
        p_next.ir   = in_item.a_imag * in_item.b_real;
        p_next.aa_r = in_item.a_real * in_item.a_real;
        p_next.aa_i = in_item.a_imag * in_item.a_imag;
        p_next.bb_r = in_item.b_real * in_item.b_real;
        p_next.bb_i = in_item.b_imag * in_item.b_imag;
        if (in_item.opcode == cau_pkg::OP_SUB)
        begin
            p_next.pre_re = {in_item.a_real[15], in_item.a_real}
                          - {in_item.b_real[15], in_item.b_real};
            p_next.pre_im = {in_item.a_imag[15], in_item.a_imag}
                          - {in_item.b_imag[15], in_item.b_imag};
        end
        else
        begin
            p_next.pre_re = {in_item.a_real[15], in_item.a_real}
                          + {in_item.b_real[15], in_item.b_real};
            p_next.pre_im = {in_item.a_imag[15], in_item.a_imag}
                          + {in_item.b_imag[15], in_item.b_imag};
        end
    end

    // Stage 2: sums of products
    always_comb
    begin
        s_next.op     = p_reg.op;
        s_next.mul_re = {p_reg.rr[31], p_reg.rr} - {p_reg.ii[31], p_reg.ii};
        s_next.mul_im = {p_reg.ri[31], p_reg.ri} + {p_reg.ir[31], p_reg.ir};
        s_next.num_re = {p_reg.rr[31], p_reg.rr} + {p_reg.ii[31], p_reg.ii};
        s_next.num_im = {p_reg.ir[31], p_reg.ir} - {p_reg.ri[31], p_reg.ri};
        s_next.den    = p_reg.bb_r + p_reg.bb_i;
        s_next.ss     = p_reg.aa_r + p_reg.aa_i;
        s_next.pre_re = p_reg.pre_re;
        s_next.pre_im = p_reg.pre_im;
    end

    // Stage 3: magnitudes, overflow screen, multiply rounding
    logic [32:0] mag_re, mag_im, mmag_re, mmag_im;
    logic [32:0] mrnd_re, mrnd_im;
    logic [24:0] mq_re, mq_im;

    always_comb
    begin
        mag_re  = s_reg.num_re[32] ? (~s_reg.num_re + 33'd1) : s_reg.num_re;
        mag_im  = s_reg.num_im[32] ? (~s_reg.num_im + 33'd1) : s_reg.num_im;
        mmag_re = s_reg.mul_re[32] ? (~s_reg.mul_re + 33'd1) : s_reg.mul_re;
        mmag_im = s_reg.mul_im[32] ? (~s_reg.mul_im + 33'd1) : s_reg.mul_im;
        mrnd_re = mmag_re + 33'd128;
        mrnd_im = mmag_im + 33'd128;
        mq_re   = s_reg.mul_re[32] ? (~mrnd_re[32:8] + 25'd1) : mrnd_re[32:8];
        mq_im   = s_reg.mul_im[32] ? (~mrnd_im[32:8] + 25'd1) : mrnd_im[32:8];

        i_next.op = s_reg.op;
        if (s_reg.op == cau_pkg::OP_MUL)
        begin
            i_next.pass_re = mq_re;
            i_next.pass_im = mq_im;
        end
        else
        begin
            i_next.pass_re = {{8{s_reg.pre_re[16]}}, s_reg.pre_re};
            i_next.pass_im = {{8{s_reg.pre_im[16]}}, s_reg.pre_im};
        end

        i_next.lre.neg  = s_reg.num_re[32];
        i_next.lre.ovf  = {16'd0, mag_re[31:0]} >= {s_reg.den, 16'd0};
        i_next.lre.m_sh = {mag_re[15:0], 8'd0};
        i_next.lre.rem  = {16'd0, mag_re[31:16]};
        i_next.lre.q    = '0;
        i_next.lim.neg  = s_reg.num_im[32];
        i_next.lim.ovf  = {16'd0, mag_im[31:0]} >= {s_reg.den, 16'd0};
        i_next.lim.m_sh = {mag_im[15:0], 8'd0};
        i_next.lim.rem  = {16'd0, mag_im[31:16]};
        i_next.lim.q    = '0;
        i_next.den      = s_reg.den;
        i_next.dz       = (s_reg.den == 32'd0);
        i_next.s_sh     = {16'd0, s_reg.ss};
        i_next.root     = '0;
        i_next.srem     = '0;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
            i_valid_reg <= s_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= p_next;
            s_reg <= s_next;
            i_reg <= i_next;
        end
    end

    assign out_valid = i_valid_reg;
    assign out_item  = i_reg;

endmodule

// File: hdl/cau_step.sv
// One iteration stage: a quotient bit for each divider lane and a root bit.
// Depends on cau_pkg.
module cau_step
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  cau_pkg::item_t in_item,
    output logic           out_valid,
    output cau_pkg::item_t out_item
);

    logic           valid_reg;
    cau_pkg::item_t item_reg, item_next;
    logic [32:0]    dsh_re, dsh_im;
    logic [18:0]    rsh, trial;

    always_comb
    begin
        item_next = in_item;

        // Restoring division, real lane
        dsh_re = {in_item.lre.rem, in_item.lre.m_sh[23]};
        item_next.lre.m_sh = {in_item.lre.m_sh[22:0], 1'b0};
        if (dsh_re >= {1'b0, in_item.den})
        begin
            item_next.lre.rem = 32'(dsh_re - {1'b0, in_item.den});
            item_next.lre.q   = {in_item.lre.q[22:0], 1'b1};
        end
        else
        begin
            item_next.lre.rem = dsh_re[31:0];
            item_next.lre.q   = {in_item.lre.q[22:0], 1'b0};
        end

        // Restoring division, imaginary lane
        dsh_im = {in_item.lim.rem, in_item.lim.m_sh[23]};
        item_next.lim.m_sh = {in_item.lim.m_sh[22:0], 1'b0};
        if (dsh_im >= {1'b0, in_item.den})
        begin
            item_next.lim.rem = 32'(dsh_im - {1'b0, in_item.den});
            item_next.lim.q   = {in_item.lim.q[22:0], 1'b1};
        end
        else
        begin
            item_next.lim.rem = dsh_im[31:0];
            item_next.lim.q   = {in_item.lim.q[22:0], 1'b0};
        end

        // Digit-by-digit square root, two radicand bits per step
        rsh   = {in_item.srem, in_item.s_sh[47:46]};
        trial = {1'b0, in_item.root, 2'b01};
        item_next.s_sh = {in_item.s_sh[45:0], 2'b00};
        if (rsh >= trial)
        begin
            item_next.srem = 17'(rsh - trial);
            item_next.root = {in_item.root[14:0], 1'b1};
        end
        else
        begin
            item_next.srem = rsh[16:0];
            item_next.root = {in_item.root[14:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: hdl/cau_back.sv
// Back end: quotient and root rounding, saturation, status and the output register.
// Depends on cau_pkg.
module cau_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cau_pkg::item_t     in_item,
    input  logic               out_ready,
    output logic               adv,
    output logic               out_valid,
    output logic signed [23:0] res_real,
    output logic signed [23:0] res_imag,
    output logic [1:0]         status
);

    logic               valid_reg;
    logic signed [23:0] re_reg, re_next, im_reg, im_next;
    logic [1:0]         st_reg, st_next;

    logic [24:0]        qr_re, qr_im;
    logic               dsat_re, dsat_im, psat_re, psat_im;
    logic signed [23:0] dv_re, dv_im, pv_re, pv_im;
    logic [15:0]        root_r;
    logic [24:0]        neg_re, neg_im;

    // The whole pipeline moves when the output register is free or being drained
    assign adv = !valid_reg || out_ready;

    always_comb
    begin
        // Quotient: round half away from zero, then clamp
        qr_re   = {1'b0, in_item.lre.q}
                + 25'({in_item.lre.rem, 1'b0} >= {1'b0, in_item.den});
        qr_im   = {1'b0, in_item.lim.q}
                + 25'({in_item.lim.rem, 1'b0} >= {1'b0, in_item.den});
        neg_re  = ~qr_re + 25'd1;
        neg_im  = ~qr_im + 25'd1;
        dsat_re = in_item.lre.ovf
                || (in_item.lre.neg ? (qr_re > 25'd8388608) : (qr_re > 25'd8388607));
        dsat_im = in_item.lim.ovf
                || (in_item.lim.neg ? (qr_im > 25'd8388608) : (qr_im > 25'd8388607));
        if (dsat_re)
            dv_re = in_item.lre.neg ? cau_pkg::RES_MIN : cau_pkg::RES_MAX;
        else
            dv_re = in_item.lre.neg ? neg_re[23:0] : qr_re[23:0];
        if (dsat_im)
            dv_im = in_item.lim.neg ? cau_pkg::RES_MIN : cau_pkg::RES_MAX;
        else
            dv_im = in_item.lim.neg ? neg_im[23:0] : qr_im[23:0];

        // Pass-through values (add, subtract, multiply) clamped to 24 bits
        psat_re = (in_item.pass_re[24] != in_item.pass_re[23]);
        psat_im = (in_item.pass_im[24] != in_item.pass_im[23]);
        pv_re   = psat_re ? (in_item.pass_re[24] ? cau_pkg::RES_MIN : cau_pkg::RES_MAX)
                          : in_item.pass_re[23:0];
        pv_im   = psat_im ? (in_item.pass_im[24] ? cau_pkg::RES_MIN : cau_pkg::RES_MAX)
                          : in_item.pass_im[23:0];

        // Root to nearest: step up when the remainder exceeds the root
        root_r  = in_item.root + 16'({1'b0, in_item.srem} > {2'b00, in_item.root});

        re_next = '0;
        im_next = '0;
        st_next = cau_pkg::ST_OK;
        case (in_item.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL:
            begin
                re_next = pv_re;
                im_next = pv_im;
                st_next = (psat_re || psat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            cau_pkg::OP_DIV:
            begin
                if (in_item.dz)
                begin
                    st_next = cau_pkg::ST_DIV0;
                end
                else
                begin
                    re_next = dv_re;
                    im_next = dv_im;
                    st_next = (dsat_re || dsat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::OP_MOD:
            begin
                re_next = {8'd0, root_r};
            end
            default:
            begin
                re_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign res_real  = re_reg;
    assign res_imag  = im_reg;
    assign status    = st_reg;

endmodule

// File: hdl/complex_arith_unit.sv
// Complex arithmetic unit top level: front end, iteration stages, back end.
// Depends on cau_pkg, cau_if, cau_front, cau_step and cau_back.
//
// Usage:
//   in_ch carries an opcode (add, subtract, multiply, divide, modulus of a)
//   and two complex Q8.8 operands; out_ch returns one Q16.8 complex result
//   and a status code (ok, saturated, divide by zero) per input transfer.
//   Results leave in the order the operands arrived.
//   Pipeline: a result passes through three front stages (products, sums,
//   preparation), 24 iteration stages (one quotient bit per lane and one
//   root bit per stage) and the output register. The depth is set by the
//   24-bit quotient of the divider.
//   Throughput: one transfer per cycle while out_ch.ready is high.
//   Stall: when a result waits and out_ch.ready is low, the whole pipeline
//   holds and in_ch.ready drops; nothing is dropped or repeated.
//   Reset: all valid bits clear, the pipeline is empty and in_ch.ready is
//   high from the first cycle after reset.
module complex_arith_unit
(
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    in_ch,
    cau_out_if.source out_ch
);

    logic              adv;
    cau_pkg::in_item_t in_item;
    logic              valid_chain [cau_pkg::DIV_STEPS+1];
    cau_pkg::item_t    item_chain  [cau_pkg::DIV_STEPS+1];

    assign in_ch.ready     = adv;
    assign in_item.opcode  = in_ch.opcode;
    assign in_item.a_real  = in_ch.a_real;
    assign in_item.a_imag  = in_ch.a_imag;
    assign in_item.b_real  = in_ch.b_real;
    assign in_item.b_imag  = in_ch.b_imag;

    cau_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_ch.valid),
        .in_item   (in_item),
        .out_valid (valid_chain[0]),
        .out_item  (item_chain[0])
    );

    // Iteration stages
    for (genvar k = 0; k < cau_pkg::DIV_STEPS; k++)
    begin : g_step
        cau_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (valid_chain[k]),
            .in_item   (item_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_item  (item_chain[k+1])
        );
    end

    cau_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_chain[cau_pkg::DIV_STEPS]),
        .in_item   (item_chain[cau_pkg::DIV_STEPS]),
        .out_ready (out_ch.ready),
        .adv       (adv),
        .out_valid (out_ch.valid),
        .res_real  (out_ch.res_real),
        .res_imag  (out_ch.res_imag),
        .status    (out_ch.status)
    );

endmodule
